[hw/rtl/pres80_pkg.sv]
package pres80_pkg;

  localparam int unsigned BlkW    = 64;
  localparam int unsigned KeyW    = 80;
  localparam int unsigned KeyHiW  = 16;
  localparam int unsigned Rounds  = 31;
  localparam int unsigned RcW     = 5;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [BlkW-1:0]    blk_t;
  typedef logic [KeyW-1:0]    key_t;
  typedef logic [RcW-1:0]     rc_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_KEY_HIGH = 2'd0;
  localparam cfg_idx_t CFG_KEY_LOW  = 2'd1;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // S-box on every nibble, then bit k of nibble j moves to bit 16k+j.
  function automatic blk_t sp_layer(blk_t x);
    blk_t       y;
    logic [3:0] nib;
    y = '0;
    for (int j = 0; j < 16; j++) begin
      nib = SBOX[x[4*j +: 4]];
      for (int k = 0; k < 4; k++) begin
        y[16*k + j] = nib[k];
      end
    end
    return y;
  endfunction

  // Key register update: rotate left by 61, S-box on the top nibble,
  // round counter into bits 19..15.
  function automatic key_t key_update(key_t k, rc_t rc);
    key_t t;
    t = {k[18:0], k[79:19]};
    t[79:76] = SBOX[t[79:76]];
    t[19:15] = t[19:15] ^ rc;
    return t;
  endfunction

endpackage

[hw/rtl/pres80_pt_if.sv]
interface pres80_pt_if;
  logic                   valid;
  logic                   ready;
  logic [pres80_pkg::BlkW-1:0] plaintext;

  modport source (output valid, output plaintext, input ready);
  modport sink   (input valid, input plaintext, output ready);
endinterface

[hw/rtl/pres80_ct_if.sv]
interface pres80_ct_if;
  logic                   valid;
  logic                   ready;
  logic [pres80_pkg::BlkW-1:0] ciphertext;

  modport source (output valid, output ciphertext, input ready);
  modport sink   (input valid, input ciphertext, output ready);
endinterface

[hw/rtl/pres80_round.sv]
module pres80_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  pres80_pkg::rc_t   rc,
  input  logic              vld_i,
  input  pres80_pkg::blk_t  state_i,
  input  pres80_pkg::key_t  key_i,
  output logic              vld_o,
  output pres80_pkg::blk_t  state_o,
  output pres80_pkg::key_t  key_o
);
  import pres80_pkg::*;

  logic vld_r;
  blk_t state_r, state_nxt;
  key_t key_r, key_nxt;

  // One full round: add round key, substitution, permutation; key update.
  always_comb begin
    state_nxt = sp_layer(state_i ^ key_i[KeyW-1 -: BlkW]);
    key_nxt   = key_update(key_i, rc);
  end

  // Valid bit is control state and resets; the payload only loads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

  assign vld_o   = vld_r;
  assign state_o = state_r;
  assign key_o   = key_r;

endmodule

[hw/rtl/present80_block_encrypt.sv]
// PRESENT-80 encryption core. Each 64-bit word on the input channel is
// encrypted under the 80-bit key held in the two configuration registers
// (index 0: key bits 79..64, index 1: key bits 63..0), and the ciphertext
// leaves on the output channel in the same order. The 31 rounds are fully
// unrolled into 31 register stages, one round and its key update per stage,
// so a new word is accepted every cycle while the output is not stalled. An
// accepted word is valid on the output once it reaches the last stage. The
// final key addition is done on the output side of the last stage. When a
// finished word is stalled at the output the whole pipeline holds. The key
// travels with each word, but it should only be written while no word is in
// flight.
module present80_block_encrypt (
  input  logic                     clk,
  input  logic                     rst_n,
  pres80_pt_if.sink                in_blk,
  pres80_ct_if.source              out_blk,
  input  logic                     cfg_we,
  input  pres80_pkg::cfg_idx_t     cfg_idx,
  input  logic [pres80_pkg::BlkW-1:0] cfg_wdata
);
  import pres80_pkg::*;

  logic [KeyHiW-1:0] key_high_r;
  blk_t              key_low_r;

  logic              en;
  logic              vld_r   [Rounds];
  blk_t              state_r [Rounds];
  key_t              key_r   [Rounds];

  // Key registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_KEY_HIGH: key_high_r <= cfg_wdata[KeyHiW-1:0];
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // The pipeline advances unless a finished word is waiting at the output.
  assign en           = !vld_r[Rounds-1] || out_blk.ready;
  assign in_blk.ready = en;

  // Round stages.
  for (genvar i = 0; i < Rounds; i++) begin : g_rnd
    if (i == 0) begin : g_first
      pres80_round u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .rc      (rc_t'(i + 1)),
        .vld_i   (in_blk.valid),
        .state_i (in_blk.plaintext),
        .key_i   ({key_high_r, key_low_r}),
        .vld_o   (vld_r[i]),
        .state_o (state_r[i]),
        .key_o   (key_r[i])
      );
    end else begin : g_next
      pres80_round u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .rc      (rc_t'(i + 1)),
        .vld_i   (vld_r[i-1]),
        .state_i (state_r[i-1]),
        .key_i   (key_r[i-1]),
        .vld_o   (vld_r[i]),
        .state_o (state_r[i]),
        .key_o   (key_r[i])
      );
    end
  end

  // Final round-key addition.
  assign out_blk.valid      = vld_r[Rounds-1];
  assign out_blk.ciphertext = state_r[Rounds-1] ^ key_r[Rounds-1][KeyW-1 -: BlkW];

  // A waiting result stops the input side.
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_blk.valid && !out_blk.ready |-> !in_blk.ready)
    else $error("input accepted while output stalled");

  // An accepted word shows up in the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_blk.valid && in_blk.ready |=> vld_r[0])
    else $error("accepted word lost at pipeline entry");

  // A word moves one stage per enabled cycle.
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[0] |=> vld_r[1])
    else $error("word lost between stages");

  // A stalled result stays valid.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[Rounds-1] && !out_blk.ready |=> vld_r[Rounds-1])
    else $error("stalled result dropped");

endmodule
